// ===== sv/lbs_pkg.sv =====
// shared types and constants for the linear blend skinning block
// no dependencies; used by linear_blend_vertex_skinning, lbs_checker and tb_top
package lbs_pkg;

  localparam int MAX_BONES_DEF  = 64;
  localparam int INFLUENCES_DEF = 4;
  localparam int WORDS_PER_BONE = 12;
  localparam int PACKED_PAIRS   = 4;
  localparam int OUT_DEPTH      = 4;

  // request kinds
  localparam logic KIND_WRITE  = 1'b0;
  localparam logic KIND_VERTEX = 1'b1;

  // control that travels with one influence down the pipe
  typedef struct packed {
    logic               valid;
    logic               live;
    logic               first;
    logic               last;
    logic signed [15:0] weight;
  } infl_ctrl_t;

endpackage

// ===== sv/linear_blend_vertex_skinning.sv =====
// linear blend skinning, four influences, palette in one wide on-chip memory
// depends on lbs_pkg
// vertex path: sequencer, row read, products, row sums, weighting, accumulate, output queue;
// min(INFLUENCES,4) bone rows per vertex from the single palette read port (one bone row a cycle)
// palette write requests behind a vertex wait for its last influence
// reset clears bone_count and all control; palette contents stay undefined until written
module linear_blend_vertex_skinning #(
  parameter int MAX_BONES  = lbs_pkg::MAX_BONES_DEF,
  parameter int INFLUENCES = lbs_pkg::INFLUENCES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               bone_count_we_i,
  input  logic [6:0]         bone_count_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               kind_i,
  input  logic [9:0]         palette_slot_i,
  input  logic signed [31:0] palette_value_i,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [31:0] pos_z_i,
  input  logic [31:0]        bone_indices_packed_i,
  input  logic [63:0]        weights_packed_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] out_x_o,
  output logic signed [31:0] out_y_o,
  output logic signed [31:0] out_z_o
);

  localparam int IW      = (MAX_BONES > 1) ? $clog2(MAX_BONES) : 1;
  localparam int ROW_W   = lbs_pkg::WORDS_PER_BONE * 32;
  localparam int NSTEP   = (INFLUENCES < lbs_pkg::PACKED_PAIRS) ? INFLUENCES
                                                               : lbs_pkg::PACKED_PAIRS;
  localparam int SLOTS   = MAX_BONES * lbs_pkg::WORDS_PER_BONE;
  localparam int LIMIT_W = 9;

  // ---------------------------------------------------------------- config
  logic [6:0] bone_count_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bone_count_q <= '0;
    end else if (bone_count_we_i) begin
      bone_count_q <= bone_count_i;
    end
  end

  // effective bone limit, clamped to the palette size
  logic [LIMIT_W-1:0] limit;
  assign limit = ({2'b0, bone_count_q} > LIMIT_W'(MAX_BONES)) ? LIMIT_W'(MAX_BONES)
                                                              : {2'b0, bone_count_q};

  // ---------------------------------------------------------------- admission
  logic       busy_q;
  logic [1:0] cnt_q;
  logic [2:0] occ_q;          // vertices admitted and not yet popped from the output queue
  logic       step_last;
  logic       in_acc, vtx_acc, wr_acc, out_pop;

  assign step_last = (cnt_q == 2'(NSTEP - 1));
  // new request may enter while the last influence of the current vertex is issued
  assign in_ready_o = (!busy_q || step_last) &&
                      (kind_i == lbs_pkg::KIND_WRITE || occ_q < 3'(lbs_pkg::OUT_DEPTH));
  assign in_acc  = in_valid_i && in_ready_o;
  assign vtx_acc = in_acc && (kind_i == lbs_pkg::KIND_VERTEX);
  assign wr_acc  = in_acc && (kind_i == lbs_pkg::KIND_WRITE);

  // ---------------------------------------------------------------- palette memory
  // one row per bone, written one word at a time
  logic [ROW_W-1:0] palette_mem [MAX_BONES];

  logic [31:0]   slot_mul;
  logic [6:0]    wr_bone;
  logic [3:0]    wr_elem;
  logic          wr_in_range;
  assign slot_mul    = 32'(palette_slot_i) * 32'd683;   // slot / 12 for slot < 1024
  assign wr_bone     = 7'(slot_mul >> 13);
  assign wr_elem     = 4'(palette_slot_i - 10'(wr_bone) * 10'd12);
  assign wr_in_range = 32'(palette_slot_i) < 32'(SLOTS);

  // current vertex held for the sequencer
  logic signed [31:0] vx_q, vy_q, vz_q;
  logic [31:0]        idx_q;
  logic [63:0]        wgt_q;

  logic signed [7:0]  cur_idx;
  logic signed [15:0] cur_w;
  logic               cur_live;
  logic [IW-1:0]      rd_addr;
  assign cur_idx  = idx_q[8*cnt_q +: 8];
  assign cur_w    = wgt_q[16*cnt_q +: 16];
  assign cur_live = (cur_w > 16'sd0) && !cur_idx[7] &&
                    ({1'b0, cur_idx} < LIMIT_W'(limit));
  assign rd_addr  = IW'({1'b0, cur_idx[6:0]});

  logic [ROW_W-1:0] row_q;
  always_ff @(posedge clk_i) begin
    if (wr_acc && wr_in_range) begin
      palette_mem[IW'(wr_bone)][32*wr_elem +: 32] <= palette_value_i;
    end
    if (busy_q && cur_live) begin
      row_q <= palette_mem[rd_addr];
    end
  end

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (vtx_acc) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q && step_last) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q  <= cnt_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (vtx_acc) begin
      vx_q  <= pos_x_i;
      vy_q  <= pos_y_i;
      vz_q  <= pos_z_i;
      idx_q <= bone_indices_packed_i;
      wgt_q <= weights_packed_i;
    end
  end

  // ---------------------------------------------------------------- stage 1: row read
  lbs_pkg::infl_ctrl_t c1_q, c2_q, c3_q, c4_q;
  logic signed [31:0]  p1_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c1_q <= '0;
    end else begin
      c1_q.valid  <= busy_q;
      c1_q.live   <= cur_live;
      c1_q.first  <= (cnt_q == 2'd0);
      c1_q.last   <= step_last;
      c1_q.weight <= cur_w;
    end
  end

  always_ff @(posedge clk_i) begin
    p1_q[0]     <= vx_q;
    p1_q[1]     <= vy_q;
    p1_q[2]     <= vz_q;
  end

  // ---------------------------------------------------------------- stage 2: nine products
  logic signed [63:0] prod_q [3][3];
  logic signed [31:0] off_q  [3];

  always_ff @(posedge clk_i) begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        prod_q[r][c] <= 64'(signed'(row_q[32*(4*r+c) +: 32])) * 64'(p1_q[c]);
      end
      off_q[r] <= signed'(row_q[32*(4*r+3) +: 32]);
    end
  end

  // ---------------------------------------------------------------- stage 3: row sums
  logic signed [49:0] t_q [3];
  always_ff @(posedge clk_i) begin
    for (int r = 0; r < 3; r++) begin
      t_q[r] <= 50'(prod_q[r][0] >>> 16) + 50'(prod_q[r][1] >>> 16) +
                50'(prod_q[r][2] >>> 16) + 50'(off_q[r]);
    end
  end

  // ---------------------------------------------------------------- stage 4: weighting
  logic signed [50:0] contrib_q [3];
  logic signed [65:0] wt [3];
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      wt[r] = 66'(c3_q.weight) * 66'(t_q[r]);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int r = 0; r < 3; r++) begin
      contrib_q[r] <= c3_q.live ? 51'(wt[r] >>> 15) : '0;
    end
  end

  // control pipeline alongside the data stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c2_q <= '0;
      c3_q <= '0;
      c4_q <= '0;
    end else begin
      c2_q <= c1_q;
      c3_q <= c2_q;
      c4_q <= c3_q;
    end
  end

  // ---------------------------------------------------------------- stage 5: accumulate
  logic signed [52:0] acc_q [3];
  logic signed [52:0] acc_d [3];
  logic signed [31:0] sat   [3];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      acc_d[r] = c4_q.first ? 53'(contrib_q[r]) : acc_q[r] + 53'(contrib_q[r]);
      if (acc_d[r] > 53'sd2147483647) begin
        sat[r] = 32'sh7fffffff;
      end else if (acc_d[r] < -53'sd2147483648) begin
        sat[r] = 32'sh80000000;
      end else begin
        sat[r] = 32'(acc_d[r]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (c4_q.valid) begin
      for (int r = 0; r < 3; r++) begin
        acc_q[r] <= acc_d[r];
      end
    end
  end

  // ---------------------------------------------------------------- output queue
  // sized with occ_q so a finished vertex always finds a free entry
  logic signed [31:0] oq_x [lbs_pkg::OUT_DEPTH];
  logic signed [31:0] oq_y [lbs_pkg::OUT_DEPTH];
  logic signed [31:0] oq_z [lbs_pkg::OUT_DEPTH];
  logic [1:0] wp_q, rp_q;
  logic [2:0] fill_q;
  logic       push;

  assign push    = c4_q.valid && c4_q.last;
  assign out_pop = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      oq_x[wp_q] <= sat[0];
      oq_y[wp_q] <= sat[1];
      oq_z[wp_q] <= sat[2];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q   <= '0;
      rp_q   <= '0;
      fill_q <= '0;
      occ_q  <= '0;
    end else begin
      if (push)    wp_q <= wp_q + 2'd1;
      if (out_pop) rp_q <= rp_q + 2'd1;
      fill_q <= fill_q + 3'(push) - 3'(out_pop);
      occ_q  <= occ_q + 3'(vtx_acc) - 3'(out_pop);
    end
  end

  assign out_valid_o = (fill_q != 3'd0);
  assign out_x_o     = oq_x[rp_q];
  assign out_y_o     = oq_y[rp_q];
  assign out_z_o     = oq_z[rp_q];

endmodule

// ===== tb/sv/lbs_checker.sv =====
// skinning result checker: watches the request and result channels,
// predicts skinned positions from its own palette copy; depends on lbs_pkg
module lbs_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               bone_count_we_i,
  input  logic [6:0]         bone_count_i,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic               kind_i,
  input  logic [9:0]         palette_slot_i,
  input  logic signed [31:0] palette_value_i,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [31:0] pos_z_i,
  input  logic [31:0]        bone_indices_packed_i,
  input  logic [63:0]        weights_packed_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic signed [31:0] out_x_i,
  input  logic signed [31:0] out_y_i,
  input  logic signed [31:0] out_z_i,
  output int                 fail_count_o,
  output int                 pending_o,
  output int                 vertex_count_o
);

  localparam int PAL_WORDS = lbs_pkg::MAX_BONES_DEF * lbs_pkg::WORDS_PER_BONE;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } skinned_pos_t;

  logic signed [31:0] palette_copy [PAL_WORDS];
  logic [6:0]         bone_limit;
  skinned_pos_t       expected_pos_q[$];

  function automatic logic signed [31:0] clamp32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic skinned_pos_t skin_vertex(input logic signed [31:0] px,
      input logic signed [31:0] py, input logic signed [31:0] pz,
      input logic [31:0] idx_pk, input logic [63:0] w_pk);
    logic signed [63:0] acc [3];
    logic signed [63:0] pos [3];
    logic signed [63:0] row_sum, prod;
    logic signed [15:0] w;
    logic signed [7:0]  idx;
    int                 lim, base;
    skinned_pos_t       res;
    pos[0] = px; pos[1] = py; pos[2] = pz;
    for (int r = 0; r < 3; r++) acc[r] = 0;
    lim = (bone_limit > lbs_pkg::MAX_BONES_DEF) ? lbs_pkg::MAX_BONES_DEF : bone_limit;
    for (int k = 0; k < lbs_pkg::PACKED_PAIRS; k++) begin
      w   = w_pk[16*k +: 16];
      idx = idx_pk[8*k +: 8];
      if (w <= 0 || idx < 0 || int'(idx) >= lim) continue;
      base = int'(idx) * lbs_pkg::WORDS_PER_BONE;
      for (int r = 0; r < 3; r++) begin
        row_sum = palette_copy[base + 4*r + 3];
        for (int c = 0; c < 3; c++) begin
          prod = palette_copy[base + 4*r + c] * pos[c];
          row_sum += prod >>> 16;
        end
        // weight product fits: 16 bits times at most 49 bits
        prod = 64'(w) * row_sum;
        acc[r] += prod >>> 15;
      end
    end
    res.x = clamp32(acc[0]);
    res.y = clamp32(acc[1]);
    res.z = clamp32(acc[2]);
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    skinned_pos_t got, want;
    if (!rst_ni) begin
      bone_limit     <= '0;
      fail_count_o   <= 0;
      vertex_count_o <= 0;
      pending_o      <= 0;
      expected_pos_q.delete();
    end else begin
      if (bone_count_we_i) bone_limit <= bone_count_i;
      if (in_valid_i && in_ready_i) begin
        if (kind_i == lbs_pkg::KIND_WRITE) begin
          if (palette_slot_i < PAL_WORDS) palette_copy[palette_slot_i] = palette_value_i;
        end else begin
          expected_pos_q.insert(expected_pos_q.size(),
                                skin_vertex(pos_x_i, pos_y_i, pos_z_i,
                                            bone_indices_packed_i, weights_packed_i));
        end
      end
      if (out_valid_i && out_ready_i) begin
        got = '{out_x_i, out_y_i, out_z_i};
        vertex_count_o <= vertex_count_o + 1;
        if (expected_pos_q.size() == 0) begin
          $error("result with no vertex pending: %h", got);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = expected_pos_q.pop_front();
          if (got.x !== want.x) $error("out_x expected %h actual %h", want.x, got.x);
          if (got.y !== want.y) $error("out_y expected %h actual %h", want.y, got.y);
          if (got.z !== want.z) $error("out_z expected %h actual %h", want.z, got.z);
          if (got !== want) fail_count_o <= fail_count_o + 1;
        end
      end
      pending_o <= expected_pos_q.size();
    end
  end

endmodule

// ===== tb/sv/tb_top.sv =====
// top-level bench for linear_blend_vertex_skinning: drives requests and
// bone_count, randomizes stalls; depends on lbs_pkg, lbs_checker and the block
module tb_top;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 20;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               bc_we = 1'b0;
  logic [6:0]         bc_val = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               kind = lbs_pkg::KIND_WRITE;
  logic [9:0]         slot = '0;
  logic signed [31:0] pval = '0, px = '0, py = '0, pz = '0;
  logic [31:0]        idx_pk = '0;
  logic [63:0]        w_pk = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] ox, oy, oz;
  int                 fails, pending, vertices;
  int                 idle_cycles = 0;
  int                 writes_sent = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  linear_blend_vertex_skinning dut (
    .clk_i(clk), .rst_ni(rst_n),
    .bone_count_we_i(bc_we), .bone_count_i(bc_val),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .kind_i(kind), .palette_slot_i(slot), .palette_value_i(pval),
    .pos_x_i(px), .pos_y_i(py), .pos_z_i(pz),
    .bone_indices_packed_i(idx_pk), .weights_packed_i(w_pk),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .out_x_o(ox), .out_y_o(oy), .out_z_o(oz)
  );

  lbs_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .bone_count_we_i(bc_we), .bone_count_i(bc_val),
    .in_valid_i(in_valid), .in_ready_i(in_ready),
    .kind_i(kind), .palette_slot_i(slot), .palette_value_i(pval),
    .pos_x_i(px), .pos_y_i(py), .pos_z_i(pz),
    .bone_indices_packed_i(idx_pk), .weights_packed_i(w_pk),
    .out_valid_i(out_valid), .out_ready_i(out_ready),
    .out_x_i(ox), .out_y_i(oy), .out_z_i(oz),
    .fail_count_o(fails), .pending_o(pending), .vertex_count_o(vertices)
  );

  // watchdog: any stretch with no accepted request or result
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("linear_blend_vertex_skinning verification failed");
      $finish;
    end
  end

  // result side: random backpressure, with calm stretches
  initial begin
    int gap;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
      repeat (gap) begin
        out_ready <= 1'b0;
        @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // one request: random gap, then hold valid until accepted
  task automatic send_request(input logic k, input logic [9:0] s, input logic [31:0] v,
      input logic [31:0] x, input logic [31:0] y, input logic [31:0] z,
      input logic [31:0] ip, input logic [63:0] wp, input bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    kind <= k; slot <= s; pval <= v;
    px <= x; py <= y; pz <= z; idx_pk <= ip; w_pk <= wp;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    if (k == lbs_pkg::KIND_WRITE) writes_sent++;
  endtask

  task automatic write_bone(input int b, input bit tame);
    for (int e = 0; e < lbs_pkg::WORDS_PER_BONE; e++)
      send_request(lbs_pkg::KIND_WRITE, 10'(b * lbs_pkg::WORDS_PER_BONE + e),
                   tame ? $urandom_range(0, 32'h3ffff) - 32'h1ffff : $urandom,
                   $urandom, $urandom, $urandom, $urandom, {$urandom, $urandom},
                   $urandom_range(0, 1));
  endtask

  // indices stay within written bones unless the bone is out of range anyway
  function automatic logic [7:0] pick_index(input int nwritten);
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'($urandom_range(128, 255));     // negative index
    if (r == 1) return 8'($urandom_range(64, 127));      // beyond palette
    return 8'($urandom_range(0, nwritten - 1));
  endfunction

  task automatic send_vertex(input logic [31:0] x, input logic [31:0] y,
      input logic [31:0] z, input logic [31:0] ip, input logic [63:0] wp);
    send_request(lbs_pkg::KIND_VERTEX, 10'($urandom), $urandom, x, y, z, ip, wp,
                 $urandom_range(0, 3) == 0);
  endtask

  // wait for all results, then let the pipe settle before touching bone_count
  task automatic drain_and_set(input logic [6:0] count);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    bc_we <= 1'b1; bc_val <= count;
    @(negedge clk);
    bc_we <= 1'b0;
  endtask

  function automatic logic [63:0] rand_weights();
    logic [63:0] w;
    for (int k = 0; k < 4; k++)
      case ($urandom_range(0, 5))
        0: w[16*k +: 16] = 16'h0000;
        1: w[16*k +: 16] = 16'($urandom_range(32768, 65535));   // negative weight
        2: w[16*k +: 16] = 16'h7fff;
        default: w[16*k +: 16] = 16'($urandom_range(1, 16384));
      endcase
    return w;
  endfunction

  initial begin
    logic [31:0] ip;
    int          nw;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: fill every bone, extremes included, then corner vertices
    for (int b = 0; b < lbs_pkg::MAX_BONES_DEF; b++) write_bone(b, b % 2 == 0);
    send_request(lbs_pkg::KIND_WRITE, 10'd1023, 32'h7fffffff, '0, '0, '0, '0, '0, 1'b0);
    send_request(lbs_pkg::KIND_WRITE, 10'd768, 32'h80000000, '0, '0, '0, '0, '0, 1'b0);
    send_request(lbs_pkg::KIND_WRITE, 10'd0, 32'h80000000, '0, '0, '0, '0, '0, 1'b0);
    send_request(lbs_pkg::KIND_WRITE, 10'd3, 32'h7fffffff, '0, '0, '0, '0, '0, 1'b0);
    drain_and_set(7'd0);
    // no bones valid: everything skipped
    send_vertex(32'h7fffffff, 32'h80000000, 32'h1, 32'h03020100, 64'h7fff_7fff_7fff_7fff);
    drain_and_set(7'd127);   // above the palette size, clamps to full palette
    send_vertex(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h3f3f0000,
                64'h7fff_7fff_7fff_7fff);
    send_vertex(32'h80000000, 32'h80000000, 32'h80000000, 32'h00000000,
                64'h7fff_7fff_7fff_7fff);
    send_vertex(32'h00010000, 32'h00020000, 32'hffff0000, 32'hff80407f,
                64'h8000_ffff_0001_0000);
    send_vertex(32'h00010000, 32'h0, 32'h0, 32'h01020304, 64'h0000_0000_0000_0000);
    send_vertex(32'hffffffff, 32'h0, 32'h7fffffff, 32'h05050505, 64'h7fff_7fff_7fff_7fff);
    drain_and_set(7'd64);
    send_vertex(32'h12345678, 32'hedcba987, 32'h0, 32'h403f3e00, 64'h1234_7fff_0001_4000);
    drain_and_set(7'd1);
    send_vertex(32'h00010000, 32'h00010000, 32'h00010000, 32'h00000100,
                64'h4000_4000_4000_4000);

    // random phases with varied bone counts
    for (int phase = 0; phase < 6; phase++) begin
      drain_and_set(7'($urandom_range(0, 127)));
      for (int i = 0; i < 20; i++) begin
        if ($urandom_range(0, 9) == 0) begin
          // palette rewrite; occasional slot past the palette is dropped
          send_request(lbs_pkg::KIND_WRITE,
                       ($urandom_range(0, 7) == 0) ? 10'($urandom_range(768, 1023))
                       : 10'($urandom_range(0, 767)), $urandom,
                       $urandom, $urandom, $urandom, $urandom, {$urandom, $urandom}, 1'b0);
        end else begin
          nw = lbs_pkg::MAX_BONES_DEF;
          for (int k = 0; k < 4; k++) ip[8*k +: 8] = pick_index(nw);
          if ($urandom_range(0, 1))
            send_vertex($urandom, $urandom, $urandom, ip, rand_weights());
          else
            send_vertex(32'($urandom_range(0, 32'h7ffff)) - 32'h3ffff,
                        32'($urandom_range(0, 32'h7ffff)) - 32'h3ffff,
                        32'($urandom_range(0, 32'h7ffff)) - 32'h3ffff, ip, rand_weights());
        end
        if (i == 10 && phase == 2) begin
          // hold off until the pipe has handed back every result
          in_valid <= 1'b0;
          while (pending != 0) @(negedge clk);
        end
      end
    end

    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("run covered %0d palette writes and %0d skinned vertices", writes_sent, vertices);
    $display("bone counts swept from zero through past the palette size");
    if (fails == 0 && pending == 0)
      $display("linear_blend_vertex_skinning verification clean");
    else
      $display("linear_blend_vertex_skinning verification failed");
    $finish;
  end
endmodule
